// ----- rtl/film_transport_step_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// Film transport step sequencer assertion macros
// Shared concurrent assertion forms for the sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef FILM_TRANSPORT_STEP_SEQUENCER_ASSERT_SVH
`define FILM_TRANSPORT_STEP_SEQUENCER_ASSERT_SVH

// same-cycle implication, reset-qualified
`define FTSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ftss assertion failed");

// next-cycle implication, reset-qualified
`define FTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ftss assertion failed");

`endif

// ----- rtl/ftss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_pkg
// Types, codes and command decode shared by the step sequencer modules.
// ----------------------------------------------------------------------------
package ftss_pkg;

	localparam int TIMER_BITS = 16;
	localparam logic [3:0] WINDOW_SAMPLES = 4'd8;

	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_HALF   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_HALF  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_HALF  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEEK_HALF  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DWELL      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES     = 3'd6;

	// register reset values
	localparam logic [15:0] RST_RUN_HALF  = 16'd500;
	localparam logic [15:0] RST_SLOW_HALF = 16'd500;
	localparam logic [15:0] RST_FAST_HALF = 16'd200;
	localparam logic [15:0] RST_SEEK_HALF = 16'd50;
	localparam logic [15:0] RST_DWELL     = 16'd10000;
	localparam logic [15:0] RST_STEPS     = 16'd32;
	localparam logic [9:0]  RST_FRAMES    = 10'd100;

	// command characters
	localparam logic [7:0] CH_A    = 8'd97;
	localparam logic [7:0] CH_B    = 8'd98;
	localparam logic [7:0] CH_C    = 8'd99;
	localparam logic [7:0] CH_D    = 8'd100;
	localparam logic [7:0] CH_E    = 8'd101;
	localparam logic [7:0] CH_F    = 8'd102;
	localparam logic [7:0] CH_G    = 8'd103;
	localparam logic [7:0] CH_H    = 8'd104;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_ONE  = 8'd49;
	localparam logic [7:0] CH_TWO  = 8'd50;
	localparam logic [7:0] CH_FOUR = 8'd52;

	typedef enum logic [3:0] {
		MODE_RESET     = 4'd0,
		MODE_FWD       = 4'd1,
		MODE_BACK      = 4'd2,
		MODE_KEEP      = 4'd3,
		MODE_KEEP_SLOW = 4'd4,
		MODE_STOP      = 4'd5,
		MODE_END       = 4'd6,
		MODE_ONE       = 4'd7,
		MODE_LOAD      = 4'd8,
		MODE_BATCH     = 4'd9,
		MODE_TEST      = 4'd10
	} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_CLOSED = 3'd1,
		PH_OPEN   = 3'd2,
		PH_SLOW   = 3'd3,
		PH_FAST   = 3'd4,
		PH_DWELL  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CONT_NONE = 2'd0,
		CONT_END  = 2'd1,
		CONT_FWD  = 2'd2,
		CONT_BACK = 2'd3
	} cont_t;

	typedef struct packed {
		logic [15:0] run_half;
		logic [15:0] slow_half;
		logic [15:0] fast_half;
		logic [15:0] seek_half;
		logic [15:0] dwell;
		logic [15:0] steps;
		logic [9:0]  frames;
	} cfg_t;

	typedef struct packed {
		logic  step;
		logic  dir;
		logic  enable_n;
		mode_t mode;
		logic  busy;
		logic  moving;
		logic  sensor_echo;
		logic  echo_valid;
	} res_t;

	typedef struct packed {
		logic  valid;
		mode_t mode;
	} cmd_t;

	function automatic cmd_t cmd_decode(input logic [7:0] b);
		cmd_t c;
		c.valid = 1'b1;
		c.mode  = MODE_END;
		case (b)
			CH_A, CH_FOUR: c.mode = MODE_RESET;
			CH_B, CH_ONE:  c.mode = MODE_FWD;
			CH_C, CH_TWO:  c.mode = MODE_BACK;
			CH_D, CH_ZERO: c.mode = MODE_STOP;
			CH_E:          c.mode = MODE_ONE;
			CH_F:          c.mode = MODE_BATCH;
			CH_G:          c.mode = MODE_LOAD;
			CH_H:          c.mode = MODE_TEST;
			default:       c.valid = 1'b0;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/ftss_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_cfg_regs
// Configuration register file: half periods, dwell and frame geometry.
// ----------------------------------------------------------------------------
module ftss_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ftss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	output ftss_pkg::cfg_t                 cfg
);
	import ftss_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_half  <= RST_RUN_HALF;
			cfg_q.slow_half <= RST_SLOW_HALF;
			cfg_q.fast_half <= RST_FAST_HALF;
			cfg_q.seek_half <= RST_SEEK_HALF;
			cfg_q.dwell     <= RST_DWELL;
			cfg_q.steps     <= RST_STEPS;
			cfg_q.frames    <= RST_FRAMES;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RUN_HALF:  cfg_q.run_half  <= cfg_data;
				CFG_SLOW_HALF: cfg_q.slow_half <= cfg_data;
				CFG_FAST_HALF: cfg_q.fast_half <= cfg_data;
				CFG_SEEK_HALF: cfg_q.seek_half <= cfg_data;
				CFG_DWELL:     cfg_q.dwell     <= cfg_data;
				CFG_STEPS:     cfg_q.steps     <= cfg_data;
				CFG_FRAMES:    cfg_q.frames    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/ftss_seq_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_seq_core
// Sequencer state and single-pass next-state logic for one beat.
// ----------------------------------------------------------------------------
module ftss_seq_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic           operation,
	input  logic [7:0]     command_byte,
	input  logic           sensor_level,
	input  ftss_pkg::cfg_t cfg,
	output ftss_pkg::res_t res
);
	import ftss_pkg::*;

	typedef struct packed {
		mode_t                 mode;
		logic                  moving;
		phase_t                phase;
		cont_t                 cont;
		logic [TIMER_BITS-1:0] timer;
		logic                  step;
		logic                  dir;
		logic                  enable_n;
		logic [15:0]           step_cnt;
		logic [9:0]            frame_cnt;
		logic [3:0]            win_cnt;
		logic [3:0]            win_sum;
		logic                  pend_valid;
		mode_t                 pend_mode;
	} seq_state_t;

	seq_state_t state_q;
	seq_state_t nxt;

	cmd_t                  cmd;
	logic [15:0]           half_sel;
	logic [TIMER_BITS-1:0] period;
	logic [TIMER_BITS-1:0] timer_inc;
	logic                  half_hit;
	logic                  dwell_hit;
	logic                  done_step;
	logic                  echo;
	logic                  echo_v;
	logic [3:0]            sum_new;
	logic [3:0]            cnt_new;

	function automatic seq_state_t step_begin(seq_state_t s);
		s.step  = 1'b1;
		s.timer = '0;
		return s;
	endfunction

	function automatic seq_state_t dwell_begin(seq_state_t s, logic [15:0] dwell);
		s.timer = '0;
		s.phase = (dwell == 16'd0) ? PH_IDLE : PH_DWELL;
		return s;
	endfunction

	function automatic seq_state_t slow_done(seq_state_t s, logic [15:0] dwell);
		cont_t c;
		c      = s.cont;
		s.cont = CONT_NONE;
		s.phase = PH_IDLE;
		if (c == CONT_END) begin
			s.mode = MODE_END;
		end else if (c == CONT_FWD || c == CONT_BACK) begin
			s.moving = 1'b1;
			s.dir    = (c == CONT_BACK);
			s = dwell_begin(s, dwell);
		end
		return s;
	endfunction

	function automatic seq_state_t slow_start(seq_state_t s, cfg_t c);
		if (c.steps == 16'd0) begin
			s = slow_done(s, c.dwell);
		end else begin
			s.phase    = PH_SLOW;
			s.step_cnt = '0;
			s = step_begin(s);
		end
		return s;
	endfunction

	function automatic seq_state_t home_start(seq_state_t s);
		s.enable_n = 1'b0;
		s.dir      = 1'b0;
		s.win_cnt  = '0;
		s.win_sum  = '0;
		s.phase    = PH_CLOSED;
		s = step_begin(s);
		return s;
	endfunction

	function automatic seq_state_t batch_start(seq_state_t s, cfg_t c);
		if (c.steps == 16'd0 || c.frames == 10'd0) begin
			s.mode  = MODE_END;
			s.phase = PH_IDLE;
		end else begin
			s.phase     = PH_FAST;
			s.step_cnt  = '0;
			s.frame_cnt = '0;
			s = step_begin(s);
		end
		return s;
	endfunction

	function automatic seq_state_t move_start(seq_state_t s, logic back, logic [15:0] dwell);
		if (!s.moving) begin
			s.cont = back ? CONT_BACK : CONT_FWD;
			s = home_start(s);
		end else begin
			s.mode   = MODE_KEEP;
			s.moving = 1'b1;
			s.dir    = back;
			s = dwell_begin(s, dwell);
		end
		return s;
	endfunction

	assign cmd = cmd_decode(command_byte);

	// half period for whatever is stepping on this tick; zero acts as one
	always_comb begin
		case (state_q.phase)
			PH_CLOSED, PH_OPEN: half_sel = cfg.seek_half;
			PH_SLOW:            half_sel = cfg.slow_half;
			PH_FAST:            half_sel = cfg.fast_half;
			default:            half_sel = cfg.run_half;
		endcase
	end

	assign period    = (half_sel == 16'd0) ? TIMER_BITS'(1) : half_sel;
	assign timer_inc = state_q.timer + TIMER_BITS'(1);
	assign half_hit  = (timer_inc >= period);
	assign dwell_hit = (timer_inc >= cfg.dwell);
	assign done_step = half_hit && !state_q.step;
	assign sum_new   = state_q.win_sum + {3'b000, ~sensor_level};
	assign cnt_new   = state_q.win_cnt + 4'd1;

	always_comb begin
		nxt    = state_q;
		echo   = 1'b0;
		echo_v = 1'b0;
		if (operation) begin
			if (cmd.valid) begin
				if (state_q.phase != PH_IDLE) begin
					nxt.pend_valid = 1'b1;
					nxt.pend_mode  = cmd.mode;
				end else begin
					nxt.mode = cmd.mode;
				end
			end
		end else if (state_q.phase == PH_IDLE) begin
			case (state_q.mode)
				MODE_RESET: begin
					nxt.cont = CONT_END;
					nxt = home_start(nxt);
				end
				MODE_FWD:  nxt = move_start(nxt, 1'b0, cfg.dwell);
				MODE_BACK: nxt = move_start(nxt, 1'b1, cfg.dwell);
				MODE_KEEP: begin
					if (half_hit) begin
						nxt.timer = '0;
						nxt.step  = ~state_q.step;
					end else begin
						nxt.timer = timer_inc;
					end
				end
				MODE_KEEP_SLOW: begin
					nxt.cont = CONT_NONE;
					nxt = slow_start(nxt, cfg);
				end
				MODE_STOP: begin
					nxt.step     = 1'b0;
					nxt.enable_n = 1'b0;
					nxt.mode     = MODE_END;
					nxt.moving   = 1'b0;
				end
				MODE_ONE: begin
					nxt.cont = CONT_END;
					nxt = slow_start(nxt, cfg);
				end
				MODE_LOAD: begin
					if (!state_q.moving) nxt.moving = 1'b1;
					else nxt.mode = MODE_KEEP_SLOW;
					nxt.dir = 1'b0;
				end
				MODE_BATCH: nxt = batch_start(nxt, cfg);
				MODE_TEST: begin
					echo   = sensor_level;
					echo_v = 1'b1;
				end
				default: ;
			endcase
		end else begin
			case (state_q.phase)
				PH_CLOSED, PH_OPEN: begin
					if (!half_hit) begin
						nxt.timer = timer_inc;
					end else begin
						nxt.timer = '0;
						nxt.step  = 1'b0;
						if (done_step) begin
							nxt.win_sum = sum_new;
							nxt.win_cnt = cnt_new;
							if (cnt_new >= WINDOW_SAMPLES) begin
								nxt.win_cnt = '0;
								nxt.win_sum = '0;
							end
							if (cnt_new >= WINDOW_SAMPLES && state_q.phase == PH_OPEN
									&& sum_new == WINDOW_SAMPLES) begin
								nxt.dir = 1'b1;
								nxt = slow_start(nxt, cfg);
							end else begin
								if (cnt_new >= WINDOW_SAMPLES && state_q.phase == PH_CLOSED
										&& sum_new == 4'd0)
									nxt.phase = PH_OPEN;
								nxt = step_begin(nxt);
							end
						end
					end
				end
				PH_SLOW: begin
					if (!half_hit) begin
						nxt.timer = timer_inc;
					end else begin
						nxt.timer = '0;
						nxt.step  = 1'b0;
						if (done_step) begin
							nxt.step_cnt = state_q.step_cnt + 16'd1;
							if (nxt.step_cnt >= cfg.steps) nxt = slow_done(nxt, cfg.dwell);
							else nxt = step_begin(nxt);
						end
					end
				end
				PH_FAST: begin
					if (!half_hit) begin
						nxt.timer = timer_inc;
					end else begin
						nxt.timer = '0;
						nxt.step  = 1'b0;
						if (done_step) begin
							nxt.step_cnt = state_q.step_cnt + 16'd1;
							if (nxt.step_cnt >= cfg.steps) begin
								nxt.step_cnt  = '0;
								nxt.frame_cnt = state_q.frame_cnt + 10'd1;
							end
							if (nxt.step_cnt == 16'd0 && nxt.frame_cnt >= cfg.frames
									&& state_q.step_cnt + 16'd1 >= cfg.steps) begin
								nxt.mode  = MODE_END;
								nxt.phase = PH_IDLE;
							end else begin
								nxt = step_begin(nxt);
							end
						end
					end
				end
				PH_DWELL: begin
					if (dwell_hit) begin
						nxt.timer = '0;
						nxt.phase = PH_IDLE;
					end else begin
						nxt.timer = timer_inc;
					end
				end
				default: nxt.phase = PH_IDLE;
			endcase
			// sequence over: take the held command
			if (nxt.phase == PH_IDLE && state_q.pend_valid) begin
				nxt.mode       = state_q.pend_mode;
				nxt.pend_valid = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode       <= MODE_END;
			state_q.moving     <= 1'b0;
			state_q.phase      <= PH_IDLE;
			state_q.cont       <= CONT_NONE;
			state_q.timer      <= '0;
			state_q.step       <= 1'b0;
			state_q.dir        <= 1'b0;
			state_q.enable_n   <= 1'b1;
			state_q.step_cnt   <= '0;
			state_q.frame_cnt  <= '0;
			state_q.win_cnt    <= '0;
			state_q.win_sum    <= '0;
			state_q.pend_valid <= 1'b0;
			state_q.pend_mode  <= MODE_END;
		end else if (fire) begin
			state_q <= nxt;
		end
	end

	assign res.step        = nxt.step;
	assign res.dir         = nxt.dir;
	assign res.enable_n    = nxt.enable_n;
	assign res.mode        = nxt.mode;
	assign res.busy        = (nxt.phase != PH_IDLE);
	assign res.moving      = nxt.moving;
	assign res.sensor_echo = echo;
	assign res.echo_valid  = echo_v;

endmodule

// ----- rtl/ftss_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_out_reg
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module ftss_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  ftss_pkg::res_t d,
	input  logic           out_ready,
	output logic           out_valid,
	output logic           in_ready,
	output ftss_pkg::res_t q
);
	import ftss_pkg::*;

	logic valid_q;
	res_t data_q;

	// free slot, or the held beat leaves this cycle
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign q         = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule

// ----- rtl/film_transport_step_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// film_transport_step_sequencer
// Stepper motor sequencer for a film transport: homing, frames and batches.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): each beat is either one tick of step
//    time (operation = 0, with the shutter sensor level) or a command byte
//    (operation = 1). Feed one tick beat per microsecond of motor time.
//  - Output channel (out_valid/out_ready): exactly one result beat per input
//    beat, in order: step/dir/enable_n line levels, mode, busy, moving flag
//    and the test-mode sensor echo.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//    write only while no beat is in flight.
//  - A beat's result is loaded into the result register at the edge that
//    accepts the beat. Throughput is one beat per cycle while the receiver
//    keeps up, set by the single next-state pass from state to result.
//  - When the receiver stalls, the result register holds its beat and
//    in_ready drops until that beat is taken; ready follows out_ready in the
//    same cycle, so no beat is lost or repeated.
//  - Reset: mode auto end, idle, step and dir low, driver disabled
//    (enable_n high), pending slot empty, registers at their defaults.
// ----------------------------------------------------------------------------
module film_transport_step_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [7:0]                     command_byte,
	input  logic                           sensor_level,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           step_out,
	output logic                           dir_out,
	output logic                           enable_n,
	output logic [3:0]                     mode_now,
	output logic                           busy_res,
	output logic                           moving,
	output logic                           sensor_echo,
	output logic                           echo_valid,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ftss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import ftss_pkg::*;

	cfg_t cfg;
	res_t res_next;
	res_t res_q;
	logic fire;

	// a beat moves when the sender offers and the result slot can take it
	assign fire = in_valid && in_ready;

	ftss_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// advance the sequencer state only on an accepted beat
	ftss_seq_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.operation    (operation),
		.command_byte (command_byte),
		.sensor_level (sensor_level),
		.cfg          (cfg),
		.res          (res_next)
	);

	// hold the result beat until the receiver takes it
	ftss_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.d         (res_next),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.in_ready  (in_ready),
		.q         (res_q)
	);

	assign step_out    = res_q.step;
	assign dir_out     = res_q.dir;
	assign enable_n    = res_q.enable_n;
	assign mode_now    = res_q.mode;
	assign busy_res    = res_q.busy;
	assign moving      = res_q.moving;
	assign sensor_echo = res_q.sensor_echo;
	assign echo_valid  = res_q.echo_valid;

endmodule

// ----- rtl/ftss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_checker
// Port-level checks for the film transport step sequencer, bound to the top.
// ----------------------------------------------------------------------------
`include "film_transport_step_sequencer_assert.svh"

module ftss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       step_out,
	input logic       dir_out,
	input logic       enable_n,
	input logic [3:0] mode_now,
	input logic       busy_res,
	input logic       echo_valid
);
	import ftss_pkg::*;

	// every accepted beat yields a result beat on the next cycle
	`FTSS_ASSERT_NEXT(a_beat_yields_result, clk, arst_n, in_valid && in_ready, out_valid)

	// a free or draining result slot never blocks the input
	`FTSS_ASSERT_IMPL(a_no_false_stall, clk, arst_n, !out_valid || out_ready, in_ready)

	// echo only reported while idle in test mode
	`FTSS_ASSERT_IMPL(a_echo_in_test, clk, arst_n, out_valid && echo_valid,
		!busy_res && mode_now == MODE_TEST)

	// stalled result keeps its line levels
	`FTSS_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready,
		$stable(step_out) && $stable(dir_out) && $stable(enable_n))

endmodule

bind film_transport_step_sequencer ftss_checker u_ftss_checker (.*);
